[rtl/dcp_pkg.sv]
package dcp_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int MASS_W      = 24;

endpackage

[rtl/dcp_item_if.sv]
interface dcp_item_if #(
    parameter int CW = dcp_pkg::COORD_W_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [CW-1:0]          first_x;
    logic signed [CW-1:0]          first_y;
    logic signed [CW-1:0]          first_z;
    logic signed [CW-1:0]          second_x;
    logic signed [CW-1:0]          second_y;
    logic signed [CW-1:0]          second_z;
    logic [dcp_pkg::MASS_W-1:0]    first_inv_mass;
    logic [dcp_pkg::MASS_W-1:0]    second_inv_mass;
    logic [CW-2:0]                 rest_length;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               first_inv_mass, second_inv_mass, rest_length,
        input  ready
    );

    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               first_inv_mass, second_inv_mass, rest_length,
        output ready
    );
endinterface

[rtl/dcp_result_if.sv]
interface dcp_result_if #(
    parameter int CW = dcp_pkg::COORD_W_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] new_first_x;
    logic signed [CW-1:0] new_first_y;
    logic signed [CW-1:0] new_first_z;
    logic signed [CW-1:0] new_second_x;
    logic signed [CW-1:0] new_second_y;
    logic signed [CW-1:0] new_second_z;
    logic                 degenerate;

    modport source (
        output valid, new_first_x, new_first_y, new_first_z,
               new_second_x, new_second_y, new_second_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, new_first_x, new_first_y, new_first_z,
               new_second_x, new_second_y, new_second_z, degenerate,
        output ready
    );
endinterface

[rtl/distance_constraint_projection.sv]
// Distance constraint projection for position based dynamics.
// The item channel carries one constraint per word: two points, their inverse
// masses and a rest length. The result channel returns the two corrected points
// and a degenerate flag, set when the points coincide or both are fixed, in
// which case the points pass unchanged. Both channels use valid and ready.
// A word is accepted every cycle while the chain is not stalled. Its result
// word passes through six arithmetic stages, one square root cell per length
// bit, one division cell per quotient bit and the output register, each
// passing its word on every cycle in which the chain is enabled.
// The whole chain moves on one enable, so when the receiver stalls with a
// result waiting, the chain holds and item ready drops until the result is
// taken; while the output register is empty the chain keeps moving.
// Reset empties every stage; no word is in flight afterwards and nothing has
// to be cleared before the first word.
module distance_constraint_projection #(
    parameter int COORD_WIDTH = dcp_pkg::COORD_W_DEF
) (
    input logic          clk,
    input logic          rst_n,
    dcp_item_if.sink     item,
    dcp_result_if.source result
);
    import dcp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = CW + 1;
    localparam int LW    = CW + 2;
    localparam int SQW   = 2 * LW;
    localparam int WSW   = MASS_W + 1;
    localparam int BW    = MW + LW;
    localparam int HB    = BW / 2;
    localparam int XW    = 2 * LW + MASS_W + 1;
    localparam int DENW  = LW + WSW;
    localparam int QW    = LW;
    localparam int SW    = CW + 4;
    localparam int LANES = 6;

    typedef struct packed {
        logic [2:0][CW-1:0] p1;
        logic [2:0][CW-1:0] p2;
        logic [2:0][MW-1:0] dmag;
        logic [2:0]         dneg;
        logic [MASS_W-1:0]  w1;
        logic [MASS_W-1:0]  w2;
        logic [CW-2:0]      rest;
        logic               degen;
    } ft_t;

    typedef struct packed {
        logic [2:0][CW-1:0] p1;
        logic [2:0][CW-1:0] p2;
        logic [2:0]         neg;
        logic               degen;
    } bt_t;

    typedef struct packed {
        logic [2:0][CW-1:0] n1;
        logic [2:0][CW-1:0] n2;
        logic               degen;
    } ot_t;

    function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
        logic [SW-1:0] hi;
        logic [SW-1:0] lo;
        hi = (SW'(1) << (CW - 1)) - SW'(1);
        lo = ~hi;
        if ($signed(v) > $signed(hi))
            return hi[CW-1:0];
        else if ($signed(v) < $signed(lo))
            return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    logic en;

    // Stage A: differences.
    ft_t            a_next;
    ft_t            a_reg;
    logic           a_vld_reg;
    logic [MW-1:0]  a_d [3];

    // Stage B: squares.
    ft_t              b_reg;
    logic             b_vld_reg;
    logic [2*MW-1:0]  b_sq_reg [3];

    // Stage C: sum of squares.
    ft_t              c_reg;
    ft_t              c_next;
    logic             c_vld_reg;
    logic [SQW-1:0]   c_sum_reg;

    // Square root chain.
    logic             sq_vld  [LW+1];
    ft_t              sq_pass [LW+1];
    logic [SQW-1:0]   sq_rem  [LW+1];
    logic [LW-1:0]    sq_res  [LW+1];

    // Stage D: length error and denominator.
    ft_t              d_reg;
    logic             d_vld_reg;
    logic [LW:0]      d_diff;
    logic [LW-1:0]    d_mag_reg;
    logic             d_neg_reg;
    logic [DENW-1:0]  d_den_reg;

    // Stage E: base products.
    ft_t              e_reg;
    logic             e_vld_reg;
    logic [BW-1:0]    e_base_reg [3];
    logic             e_neg_reg;
    logic [DENW-1:0]  e_den_reg;

    // Stage F: partial products with the inverse masses.
    bt_t                      f_reg;
    logic                     f_vld_reg;
    logic [DENW-1:0]          f_den_reg;
    logic [HB+MASS_W-1:0]     f_lo_reg [LANES];
    logic [BW-HB+MASS_W-1:0]  f_hi_reg [LANES];

    // Division chain.
    logic             dv_vld  [QW+1];
    bt_t              dv_pass [QW+1];
    logic [DENW-1:0]  dv_den  [QW+1];
    logic [XW-1:0]    dv_rem  [QW+1][LANES];
    logic [QW-1:0]    dv_q    [QW+1][LANES];

    // Output register.
    ot_t              out_reg;
    ot_t              out_next;
    logic             out_vld_reg;

    assign en          = !out_vld_reg || result.ready;
    assign item.ready  = en;

    always_comb
    begin
        a_next.p1[0] = item.first_x;
        a_next.p1[1] = item.first_y;
        a_next.p1[2] = item.first_z;
        a_next.p2[0] = item.second_x;
        a_next.p2[1] = item.second_y;
        a_next.p2[2] = item.second_z;
        a_next.w1    = item.first_inv_mass;
        a_next.w2    = item.second_inv_mass;
        a_next.rest  = item.rest_length;
        a_next.degen = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            a_d[i] = {a_next.p2[i][CW-1], a_next.p2[i]} - {a_next.p1[i][CW-1], a_next.p1[i]};
            a_next.dneg[i] = a_d[i][MW-1];
            a_next.dmag[i] = a_d[i][MW-1] ? (MW'(0) - a_d[i]) : a_d[i];
        end
    end

    always_comb
    begin
        c_next       = b_reg;
        c_next.degen = ((b_sq_reg[0] | b_sq_reg[1] | b_sq_reg[2]) == '0)
                       || ((WSW'(b_reg.w1) + WSW'(b_reg.w2)) == '0);
    end

    assign d_diff = {1'b0, sq_res[LW]} - (LW+1)'(sq_pass[LW].rest);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= item.valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= sq_vld[LW];
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            out_vld_reg <= dv_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;

            b_reg <= a_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i] <= a_reg.dmag[i] * a_reg.dmag[i];
            end

            c_reg     <= c_next;
            c_sum_reg <= SQW'(b_sq_reg[0]) + SQW'(b_sq_reg[1]) + SQW'(b_sq_reg[2]);

            d_reg     <= sq_pass[LW];
            d_neg_reg <= d_diff[LW];
            d_mag_reg <= d_diff[LW] ? LW'(-d_diff) : d_diff[LW-1:0];
            d_den_reg <= DENW'(sq_res[LW]) * DENW'(WSW'(sq_pass[LW].w1) + WSW'(sq_pass[LW].w2));

            e_reg     <= d_reg;
            e_neg_reg <= d_neg_reg;
            e_den_reg <= d_den_reg;
            for (int i = 0; i < 3; i++)
            begin
                e_base_reg[i] <= BW'(d_reg.dmag[i]) * BW'(d_mag_reg);
            end

            f_reg.p1    <= e_reg.p1;
            f_reg.p2    <= e_reg.p2;
            f_reg.neg   <= e_reg.dneg ^ {3{e_neg_reg}};
            f_reg.degen <= e_reg.degen;
            f_den_reg   <= e_den_reg;
            for (int i = 0; i < 3; i++)
            begin
                f_lo_reg[i]   <= e_base_reg[i][HB-1:0] * e_reg.w1;
                f_hi_reg[i]   <= e_base_reg[i][BW-1:HB] * e_reg.w1;
                f_lo_reg[3+i] <= e_base_reg[i][HB-1:0] * e_reg.w2;
                f_hi_reg[3+i] <= e_base_reg[i][BW-1:HB] * e_reg.w2;
            end

            out_reg <= out_next;
        end
    end

    assign sq_vld[0]  = c_vld_reg;
    assign sq_pass[0] = c_reg;
    assign sq_rem[0]  = c_sum_reg;
    assign sq_res[0]  = '0;

    for (genvar k = 0; k < LW; k++)
    begin : g_sqrt
        dcp_sqrt_cell #(
            .SQW    (SQW),
            .LW     (LW),
            .BIT    (LW - 1 - k),
            .pass_t (ft_t)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sq_vld[k]),
            .pass_in  (sq_pass[k]),
            .rem_in   (sq_rem[k]),
            .res_in   (sq_res[k]),
            .vld_out  (sq_vld[k+1]),
            .pass_out (sq_pass[k+1]),
            .rem_out  (sq_rem[k+1]),
            .res_out  (sq_res[k+1])
        );
    end

    assign dv_vld[0]  = f_vld_reg;
    assign dv_pass[0] = f_reg;
    assign dv_den[0]  = f_den_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dv_rem[0][l] = (XW'(f_hi_reg[l]) << HB) + XW'(f_lo_reg[l]);
            dv_q[0][l]   = '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        dcp_div_cell #(
            .XW     (XW),
            .DENW   (DENW),
            .QW     (QW),
            .LANES  (LANES),
            .BIT    (QW - 1 - k),
            .pass_t (bt_t)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (dv_vld[k]),
            .pass_in  (dv_pass[k]),
            .den_in   (dv_den[k]),
            .rem_in   (dv_rem[k]),
            .q_in     (dv_q[k]),
            .vld_out  (dv_vld[k+1]),
            .pass_out (dv_pass[k+1]),
            .den_out  (dv_den[k+1]),
            .rem_out  (dv_rem[k+1]),
            .q_out    (dv_q[k+1])
        );
    end

    always_comb
    begin
        logic [SW-1:0] c1;
        logic [SW-1:0] c2;
        out_next.degen = dv_pass[QW].degen;
        for (int i = 0; i < 3; i++)
        begin
            c1 = SW'(dv_q[QW][i]);
            c2 = SW'(dv_q[QW][3+i]);
            if (dv_pass[QW].neg[i])
            begin
                c1 = SW'(0) - c1;
                c2 = SW'(0) - c2;
            end
            if (dv_pass[QW].degen)
            begin
                out_next.n1[i] = dv_pass[QW].p1[i];
                out_next.n2[i] = dv_pass[QW].p2[i];
            end
            else
            begin
                out_next.n1[i] = sat(SW'($signed(dv_pass[QW].p1[i])) + c1);
                out_next.n2[i] = sat(SW'($signed(dv_pass[QW].p2[i])) - c2);
            end
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.new_first_x  = out_reg.n1[0];
    assign result.new_first_y  = out_reg.n1[1];
    assign result.new_first_z  = out_reg.n1[2];
    assign result.new_second_x = out_reg.n2[0];
    assign result.new_second_y = out_reg.n2[1];
    assign result.new_second_z = out_reg.n2[2];
    assign result.degenerate   = out_reg.degen;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && dv_vld[QW]) |=> dv_vld[QW])
        else $error("A word at the end of the division chain was lost during a stall.");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld[LW] && !sq_pass[LW].degen) |-> (sq_res[LW] != '0))
        else $error("Zero length reached the projection without the degenerate flag.");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld_reg && !f_reg.degen) |-> (f_den_reg != '0))
        else $error("Zero denominator entered the division chain.");

endmodule

[rtl/dcp_sqrt_cell.sv]
module dcp_sqrt_cell #(
    parameter int  SQW = 68,
    parameter int  LW  = 34,
    parameter int  BIT = 0,
    parameter type pass_t = logic
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vld_in,
    input  pass_t          pass_in,
    input  logic [SQW-1:0] rem_in,
    input  logic [LW-1:0]  res_in,
    output logic           vld_out,
    output pass_t          pass_out,
    output logic [SQW-1:0] rem_out,
    output logic [LW-1:0]  res_out
);
    import dcp_pkg::*;

    logic           vld_reg;
    pass_t          pass_reg;
    logic [SQW-1:0] rem_reg;
    logic [SQW-1:0] rem_next;
    logic [LW-1:0]  res_reg;
    logic [LW-1:0]  res_next;
    logic [SQW:0]   trial;
    logic           take;

    // Trial value is (2*res + 2^BIT) * 2^BIT, the growth of res^2 when this bit is set.
    assign trial = ((SQW+1)'(res_in) << (BIT + 1)) + ((SQW+1)'(1) << (2 * BIT));
    assign take  = {1'b0, rem_in} >= trial;

    always_comb
    begin
        rem_next = rem_in;
        res_next = res_in;
        if (take)
        begin
            rem_next = rem_in - trial[SQW-1:0];
            res_next = res_in | (LW'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_reg <= pass_in;
            rem_reg  <= rem_next;
            res_reg  <= res_next;
        end
    end

    assign vld_out  = vld_reg;
    assign pass_out = pass_reg;
    assign rem_out  = rem_reg;
    assign res_out  = res_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> ({1'b0, rem_reg} <
            (((SQW+1)'(res_reg) << (BIT + 1)) + ((SQW+1)'(1) << (2 * BIT)))))
        else $error("Square root remainder exceeds its bound.");

    a_res_low: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> ((res_reg & ((LW'(1) << BIT) - LW'(1))) == '0))
        else $error("Square root has bits set below the current position.");

endmodule

[rtl/dcp_div_cell.sv]
module dcp_div_cell #(
    parameter int  XW    = 83,
    parameter int  DENW  = 59,
    parameter int  QW    = 34,
    parameter int  LANES = 6,
    parameter int  BIT   = 0,
    parameter type pass_t = logic
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  pass_t           pass_in,
    input  logic [DENW-1:0] den_in,
    input  logic [XW-1:0]   rem_in [LANES],
    input  logic [QW-1:0]   q_in   [LANES],
    output logic            vld_out,
    output pass_t           pass_out,
    output logic [DENW-1:0] den_out,
    output logic [XW-1:0]   rem_out [LANES],
    output logic [QW-1:0]   q_out   [LANES]
);
    import dcp_pkg::*;

    logic            vld_reg;
    pass_t           pass_reg;
    logic [DENW-1:0] den_reg;
    logic [XW-1:0]   rem_reg  [LANES];
    logic [XW-1:0]   rem_next [LANES];
    logic [QW-1:0]   q_reg    [LANES];
    logic [QW-1:0]   q_next   [LANES];
    logic [XW-1:0]   trial;

    assign trial = XW'(den_in) << BIT;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[l] = rem_in[l];
            q_next[l]   = q_in[l];
            if (rem_in[l] >= trial)
            begin
                rem_next[l] = rem_in[l] - trial;
                q_next[l]   = q_in[l] | (QW'(1) << BIT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_reg <= pass_in;
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
        end
    end

    assign vld_out  = vld_reg;
    assign pass_out = pass_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;

    a_rem_first: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && den_reg != '0) |-> (rem_reg[0] < (XW'(den_reg) << BIT)))
        else $error("Division remainder of the first lane exceeds its bound.");

    a_rem_last: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && den_reg != '0) |-> (rem_reg[LANES-1] < (XW'(den_reg) << BIT)))
        else $error("Division remainder of the last lane exceeds its bound.");

endmodule

[verif/dcp_projection_checker.sv]
`timescale 1ns / 1ps

module dcp_projection_checker (
    input  logic   clk,
    input  logic   rst_n,
    dcp_item_if    item,
    dcp_result_if  result,
    output int     fail_count,
    output int     pending,
    output int     checked,
    output int     degenerate_seen
);

    localparam int CW = dcp_pkg::COORD_W_DEF;
    localparam int MW = dcp_pkg::MASS_W;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic signed [CW-1:0] second_z;
        logic                 degenerate;
    } points_t;

    points_t corrected_q[$];

    function automatic logic signed [CW-1:0] clamp_coord(logic signed [63:0] v);
        logic signed [63:0] top_val;
        logic signed [63:0] bot_val;
        top_val = (64'sd1 <<< (CW - 1)) - 1;
        bot_val = -top_val - 1;
        if (v > top_val)
            return top_val[CW-1:0];
        if (v < bot_val)
            return bot_val[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic points_t project_pair(
        logic signed [CW-1:0] p1 [3],
        logic signed [CW-1:0] p2 [3],
        logic [MW-1:0] w1,
        logic [MW-1:0] w2,
        logic [CW-2:0] rest
    );
        points_t            r;
        logic signed [63:0] delta [3];
        logic [127:0]       dmag [3];
        logic [127:0]       sq;
        logic [127:0]       cand;
        logic [127:0]       len;
        logic signed [63:0] diff;
        logic [127:0]       diff_mag;
        logic [127:0]       wsum;
        logic [127:0]       den;
        logic [127:0]       base;
        logic [127:0]       q1;
        logic [127:0]       q2;
        logic signed [63:0] c1;
        logic signed [63:0] c2;
        logic               neg;
        logic signed [63:0] n1 [3];
        logic signed [63:0] n2 [3];
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            delta[i] = 64'(p2[i]) - 64'(p1[i]);
            dmag[i] = (delta[i] < 0) ? 128'(-delta[i]) : 128'(delta[i]);
            sq = sq + dmag[i] * dmag[i];
            n1[i] = 64'(p1[i]);
            n2[i] = 64'(p2[i]);
        end
        wsum = 128'(w1) + 128'(w2);
        r.degenerate = (sq == 0) || (wsum == 0);
        if (!r.degenerate)
        begin
            len = '0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = len | (128'd1 << b);
                if (cand * cand <= sq)
                    len = cand;
            end
            diff = $signed(len[63:0]) - $signed(64'(rest));
            diff_mag = (diff < 0) ? 128'(-diff) : 128'(diff);
            den = len * wsum;
            for (int i = 0; i < 3; i++)
            begin
                base = dmag[i] * diff_mag;
                q1 = (base * 128'(w1)) / den;
                q2 = (base * 128'(w2)) / den;
                neg = (delta[i] < 0) != (diff < 0);
                c1 = neg ? -$signed(q1[63:0]) : $signed(q1[63:0]);
                c2 = neg ? -$signed(q2[63:0]) : $signed(q2[63:0]);
                n1[i] = n1[i] + c1;
                n2[i] = n2[i] - c2;
            end
        end
        r.first_x  = clamp_coord(n1[0]);
        r.first_y  = clamp_coord(n1[1]);
        r.first_z  = clamp_coord(n1[2]);
        r.second_x = clamp_coord(n2[0]);
        r.second_y = clamp_coord(n2[1]);
        r.second_z = clamp_coord(n2[2]);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
        fail_count++;
        $display("mismatch on result %0d, %s: got %h, expected %h", checked, field, got, want);
    endtask

    assign pending = corrected_q.size();

    always @(posedge clk)
    begin
        logic signed [CW-1:0] p1 [3];
        logic signed [CW-1:0] p2 [3];
        points_t want;
        if (rst_n && item.valid && item.ready)
        begin
            p1[0] = item.first_x;
            p1[1] = item.first_y;
            p1[2] = item.first_z;
            p2[0] = item.second_x;
            p2[1] = item.second_y;
            p2[2] = item.second_z;
            corrected_q.push_back(project_pair(p1, p2, item.first_inv_mass,
                item.second_inv_mass, item.rest_length));
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (corrected_q.size() == 0)
            begin
                fail_count++;
                $display("result word with nothing expected");
            end
            else
            begin
                want = corrected_q.pop_front();
                if (result.new_first_x !== want.first_x)
                    report_mismatch("new_first_x", result.new_first_x, want.first_x);
                if (result.new_first_y !== want.first_y)
                    report_mismatch("new_first_y", result.new_first_y, want.first_y);
                if (result.new_first_z !== want.first_z)
                    report_mismatch("new_first_z", result.new_first_z, want.first_z);
                if (result.new_second_x !== want.second_x)
                    report_mismatch("new_second_x", result.new_second_x, want.second_x);
                if (result.new_second_y !== want.second_y)
                    report_mismatch("new_second_y", result.new_second_y, want.second_y);
                if (result.new_second_z !== want.second_z)
                    report_mismatch("new_second_z", result.new_second_z, want.second_z);
                if (result.degenerate !== want.degenerate)
                    report_mismatch("degenerate", CW'(result.degenerate), CW'(want.degenerate));
                if (want.degenerate)
                    degenerate_seen++;
                checked++;
            end
        end
    end

endmodule

[verif/distance_constraint_projection_test.sv]
`timescale 1ns / 1ps

module distance_constraint_projection_test;

    localparam int CW = dcp_pkg::COORD_W_DEF;
    localparam int MW = dcp_pkg::MASS_W;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LATENCY = 2 * CW + 12;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   degenerate_seen;
    int   sent;
    int   burst_left;
    int   stall_phase;

    dcp_item_if   #(.CW(CW)) item ();
    dcp_result_if #(.CW(CW)) result ();

    distance_constraint_projection #(.COORD_WIDTH(CW)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .result(result)
    );

    dcp_projection_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .result(result),
        .fail_count(fail_count),
        .pending(pending),
        .checked(checked),
        .degenerate_seen(degenerate_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 300) % 4)
            0: result.ready = 1'b1;
            1: result.ready = ($urandom_range(0, 3) != 0);
            2: result.ready = ($urandom_range(0, 1) == 0);
            default: result.ready = ((stall_phase % 40) < 8);
        endcase
    end

    task automatic send_pair(
        logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] az,
        logic [CW-1:0] bx, logic [CW-1:0] by, logic [CW-1:0] bz,
        logic [MW-1:0] wa, logic [MW-1:0] wb, logic [CW-2:0] rest
    );
        if (burst_left == 0)
        begin
            item.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        item.first_x = ax;
        item.first_y = ay;
        item.first_z = az;
        item.second_x = bx;
        item.second_y = by;
        item.second_z = bz;
        item.first_inv_mass = wa;
        item.second_inv_mass = wb;
        item.rest_length = rest;
        item.valid = 1'b1;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int kind);
        logic [CW-1:0] v;
        v = $urandom();
        case (kind)
            0: v = CW'($signed(v[19:0]));
            1: v = CW'($signed(v[27:0]));
            default: v = v;
        endcase
        return v;
    endfunction

    function automatic logic [MW-1:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {MW{1'b1}};
            2: return MW'($urandom_range(1, 255));
            default: return MW'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] az;
        logic [CW-1:0] maxc;
        logic [CW-1:0] minc;
        logic [CW-2:0] rest;
        int kind;
        int waited;
        maxc = {1'b0, {(CW-1){1'b1}}};
        minc = {1'b1, {(CW-1){1'b0}}};
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.first_x = '0;
        item.first_y = '0;
        item.first_z = '0;
        item.second_x = '0;
        item.second_y = '0;
        item.second_z = '0;
        item.first_inv_mass = '0;
        item.second_inv_mass = '0;
        item.rest_length = '0;
        sent = 0;
        burst_left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pair('0, '0, '0, '0, '0, '0, 24'h010000, 24'h010000, '0);
        send_pair(32'h00010000, '1, maxc, 32'h00010000, '1, maxc, 24'h010000, 24'h1, 31'h10000);
        send_pair('0, '0, '0, 32'h00030000, '0, '0, '0, '0, 31'h10000);
        send_pair('0, '0, '0, 32'h00030000, 32'h00040000, '0, 24'h010000, 24'h010000,
                  31'h10000);
        send_pair('0, '0, '0, 32'h00030000, 32'h00040000, '0, '0, 24'h010000, 31'h10000);
        send_pair('0, '0, '0, 32'h00030000, 32'h00040000, '0, 24'h010000, '0, 31'h10000);
        send_pair('0, '0, '0, 32'h00000001, '0, '0, 24'h1, 24'h1, '1);
        send_pair(maxc, maxc, maxc, minc, minc, minc, '1, '1, '0);
        send_pair(minc, minc, minc, maxc, maxc, maxc, '1, '1, '0);
        send_pair(maxc, '0, '0, minc, '0, '0, '1, 24'h1, '1);
        send_pair(minc, maxc, minc, maxc, minc, maxc, 24'h1, '1, '1);
        send_pair(maxc, maxc, maxc, maxc - 1, maxc, maxc, '1, '1, '1);
        send_pair(minc, '0, maxc, minc, '0, maxc, '1, '1, '1);
        send_pair('1, '1, '1, '0, '0, '0, 24'h800000, 24'h800000, 31'h1);
        send_pair(32'h00050000, 32'hFFFB0000, '0, 32'hFFFB0000, 32'h00050000, '0,
                  24'h010000, 24'h020000, 31'h100000);
        send_pair(maxc, minc, '1, minc, maxc, 32'h1, '1, '0, '1);
        send_pair('0, '0, '0, '0, '0, 32'h7FFF0000, '0, '1, 31'h7FFF0000);
        send_pair(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'h12345678, 32'h9ABCDEF1,
                  32'h0F0F0F0F, 24'h123456, 24'hABCDEF, 31'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 9);
            kind = (kind < 5) ? 0 : ((kind < 8) ? 1 : 2);
            ax = rand_coord(kind);
            ay = rand_coord(kind);
            az = rand_coord(kind);
            rest = (CW-1)'($urandom());
            if (kind == 0)
                rest = rest & 31'h001FFFFF;
            else if (kind == 1)
                rest = rest & 31'h1FFFFFFF;
            if ($urandom_range(0, 30) == 0)
                send_pair(ax, ay, az, ax, ay, az, rand_mass(), rand_mass(), rest);
            else if (kind == 0)
                send_pair(ax, ay, az, ax + rand_coord(0), ay + rand_coord(0),
                          az + rand_coord(0), rand_mass(), rand_mass(), rest);
            else
                send_pair(ax, ay, az, rand_coord(kind), rand_coord(kind), rand_coord(kind),
                          rand_mass(), rand_mass(), rest);
        end
        item.valid = 1'b0;

        waited = 0;
        while (pending != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge clk);
        $display("%0d constraints sent, %0d results checked, %0d of them degenerate.",
                 sent, checked, degenerate_seen);
        $display("Stimulus mixed near, far and saturating pairs under bursty input and stalls.");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
